### hw/rtl/pdc_pkg.sv
// pdc_pkg: types, register indexes, reset tints and the tint arithmetic
// for the pixel difference colorizer. No dependencies.
package pdc_pkg;

    localparam int ChanWidth  = 8;
    localparam int ColorWidth = 3 * ChanWidth;
    localparam int SumWidth   = ChanWidth + 2;
    localparam int CfgIdxWidth = 2;

    typedef logic [ChanWidth-1:0]   t_chan;
    typedef logic [ColorWidth-1:0]  t_color;
    typedef logic [CfgIdxWidth-1:0] t_cfg_idx;

    typedef enum logic [1:0] {
        CLS_BOTH   = 2'd0,
        CLS_A_ONLY = 2'd1,
        CLS_B_ONLY = 2'd2
    } t_class;

    localparam t_cfg_idx CFG_COLOR_A_ONLY = 2'd0;
    localparam t_cfg_idx CFG_COLOR_B_ONLY = 2'd1;
    localparam t_cfg_idx CFG_COLOR_BOTH   = 2'd2;

    localparam t_color RST_COLOR_A_ONLY = 24'hFF0000;
    localparam t_color RST_COLOR_B_ONLY = 24'h00FF00;
    localparam t_color RST_COLOR_BOTH   = 24'hDCDCDC;

    // 255 - ceil((255 - tint) * dark / 255).
    // x / 255 for x < 255*257 is (x + 1 + (x >> 8)) >> 8, adds only.
    function automatic t_chan tint_channel(input t_chan tint, input t_chan dark);
        logic [15:0] prod;
        logic [16:0] x;
        logic [17:0] y;
        t_chan       up;
        prod = 16'(8'hFF - tint) * 16'(dark);
        x    = 17'(prod) + 17'd254;
        y    = 18'(x) + 18'd1 + 18'(x >> 8);
        up   = y[15:8];
        return 8'hFF - up;
    endfunction

endpackage

### hw/rtl/pixel_diff_colorize.sv
// Pixel difference colorizer: one input register, one result register,
// classification and tint arithmetic in between. Uses pdc_pkg.
//
// One pixel pair per clock: o_busy stays low, so i_start may be high in
// every cycle. Each accepted word gives one result word on o_valid once it
// has passed the input register and then the result register; the receiver
// cannot stall, so results must be taken when o_valid is high. Tint
// registers are written through the cfg channel, which is always ready;
// write them only while no pixel is in flight. Index 3 is ignored.
module pixel_diff_colorize (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [7:0]            i_a_red,
    input  logic [7:0]            i_a_green,
    input  logic [7:0]            i_a_blue,
    input  logic [7:0]            i_b_red,
    input  logic [7:0]            i_b_green,
    input  logic [7:0]            i_b_blue,
    output logic                  o_valid,
    output logic [7:0]            o_out_red,
    output logic [7:0]            o_out_green,
    output logic [7:0]            o_out_blue,
    output logic [1:0]            o_pixel_class,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  pdc_pkg::t_cfg_idx     i_cfg_index,
    input  pdc_pkg::t_color       i_cfg_data
);
    import pdc_pkg::*;

    t_color r_color_a_only;
    t_color r_color_b_only;
    t_color r_color_both;

    logic  r_in_vld;
    t_chan r_ar, r_ag, r_ab, r_br, r_bg, r_bb;

    logic   r_out_vld;
    t_chan  r_out_red, r_out_green, r_out_blue;
    t_class r_class;

    logic [SumWidth-1:0] sum_a, sum_b;
    t_class n_class;
    t_color tint;
    t_chan  dark;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // tint registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_a_only <= RST_COLOR_A_ONLY;
            r_color_b_only <= RST_COLOR_B_ONLY;
            r_color_both   <= RST_COLOR_BOTH;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_COLOR_A_ONLY: r_color_a_only <= i_cfg_data;
                CFG_COLOR_B_ONLY: r_color_b_only <= i_cfg_data;
                CFG_COLOR_BOTH:   r_color_both   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_ar <= i_a_red;
            r_ag <= i_a_green;
            r_ab <= i_a_blue;
            r_br <= i_b_red;
            r_bg <= i_b_green;
            r_bb <= i_b_blue;
        end
    end

    // classify and pick tint and source darkness
    always_comb begin
        sum_a = SumWidth'(r_ar) + SumWidth'(r_ag) + SumWidth'(r_ab);
        sum_b = SumWidth'(r_br) + SumWidth'(r_bg) + SumWidth'(r_bb);
        if (sum_a == sum_b) begin
            n_class = CLS_BOTH;
            tint    = r_color_both;
            dark    = 8'hFF - (r_br | r_bg | r_bb);
        end else if (sum_a < sum_b) begin
            n_class = CLS_A_ONLY;
            tint    = r_color_a_only;
            dark    = 8'hFF - (r_ar | r_ag | r_ab);
        end else begin
            n_class = CLS_B_ONLY;
            tint    = r_color_b_only;
            dark    = 8'hFF - (r_br | r_bg | r_bb);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_out_red   <= tint_channel(tint[23:16], dark);
            r_out_green <= tint_channel(tint[15:8], dark);
            r_out_blue  <= tint_channel(tint[7:0], dark);
            r_class     <= n_class;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_out_red     = r_out_red;
    assign o_out_green   = r_out_green;
    assign o_out_blue    = r_out_blue;
    assign o_pixel_class = r_class;

`ifndef SYNTHESIS
    a_result_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, 2))
        else $error("result word without a start two cycles earlier");

    a_start_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> ##1 o_valid)
        else $error("accepted word produced no result");

    a_class_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pixel_class != 2'd3))
        else $error("class code 3 on output");
`endif

endmodule

### dv/tb.sv
// tb: self-checking bench for pixel_diff_colorize, with its own tint predictor,
// a queue-fed pixel driver and a result monitor. Depends on pdc_pkg and the RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pdc_pkg::*;

    localparam int SettleCycles  = 8;
    localparam int WatchdogLimit = 4000;
    localparam int SegmentWords  = 265;
    localparam t_cfg_idx CFG_UNUSED = 2'd3;

    typedef struct packed {
        t_chan r;
        t_chan g;
        t_chan b;
    } t_rgb;

    typedef struct packed {
        t_rgb a;
        t_rgb b;
    } t_pair;

    typedef struct packed {
        t_chan  r;
        t_chan  g;
        t_chan  b;
        t_class cls;
    } t_tinted;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_start = 1'b0;
    t_chan    i_a_red = '0;
    t_chan    i_a_green = '0;
    t_chan    i_a_blue = '0;
    t_chan    i_b_red = '0;
    t_chan    i_b_green = '0;
    t_chan    i_b_blue = '0;
    logic     i_cfg_valid = 1'b0;
    t_cfg_idx i_cfg_index = '0;
    t_color   i_cfg_data = '0;
    logic     o_busy;
    logic     o_valid;
    t_chan    o_out_red;
    t_chan    o_out_green;
    t_chan    o_out_blue;
    logic [1:0] o_pixel_class;
    logic     o_cfg_ready;

    pixel_diff_colorize u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_a_red       (i_a_red),
        .i_a_green     (i_a_green),
        .i_a_blue      (i_a_blue),
        .i_b_red       (i_b_red),
        .i_b_green     (i_b_green),
        .i_b_blue      (i_b_blue),
        .o_valid       (o_valid),
        .o_out_red     (o_out_red),
        .o_out_green   (o_out_green),
        .o_out_blue    (o_out_blue),
        .o_pixel_class (o_pixel_class),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    t_pair   pixel_pairs_q[$];
    t_tinted tinted_q[$];
    t_pair   next_pair;
    t_tinted oldest;
    t_color  tint_a_only = RST_COLOR_A_ONLY;
    t_color  tint_b_only = RST_COLOR_B_ONLY;
    t_color  tint_both   = RST_COLOR_BOTH;
    int unsigned gap_pct = 16;
    int unsigned fail_cnt = 0;
    int unsigned idle_cycles = 0;
    logic    word_taken = 1'b0;

    // corner pixel pairs, image A in the upper 24 bits
    localparam logic [47:0] CornerPairs [12] = '{
        48'h000000_000000, 48'hFFFFFF_FFFFFF, 48'h000000_FFFFFF, 48'hFFFFFF_000000,
        48'h010000_000000, 48'h000000_000001, 48'hFF0000_00FF00, 48'h0A141E_1E140A,
        48'h804020_FFFFFE, 48'hFFFEFF_010204, 48'h55AA55_AA55AA, 48'h0000FF_7F8000
    };

    function automatic t_chan shade(t_chan tint_chan, int dark);
        return t_chan'(255 - ((255 - int'(tint_chan)) * dark + 254) / 255);
    endfunction

    function automatic t_tinted colorize(t_pair px);
        t_tinted res;
        t_color  tint;
        t_rgb    src;
        int      sum_a;
        int      sum_b;
        int      dark;
        sum_a = int'(px.a.r) + int'(px.a.g) + int'(px.a.b);
        sum_b = int'(px.b.r) + int'(px.b.g) + int'(px.b.b);
        if (sum_a == sum_b) begin
            tint    = tint_both;
            src     = px.b;
            res.cls = CLS_BOTH;
        end else if (sum_a < sum_b) begin
            tint    = tint_a_only;
            src     = px.a;
            res.cls = CLS_A_ONLY;
        end else begin
            tint    = tint_b_only;
            src     = px.b;
            res.cls = CLS_B_ONLY;
        end
        dark  = 255 - int'(src.r | src.g | src.b);
        res.r = shade(tint[23:16], dark);
        res.g = shade(tint[15:8], dark);
        res.b = shade(tint[7:0], dark);
        return res;
    endfunction

    // mostly dim pixels so the darkness term covers its whole range
    function automatic t_rgb rand_rgb();
        t_rgb px;
        int unsigned w;
        w = $urandom_range(8, 1);
        case ($urandom_range(9))
            0: px = '0;
            1: px = '1;
            default: begin
                px.r = t_chan'($urandom_range((1 << w) - 1));
                px.g = t_chan'($urandom_range((1 << w) - 1));
                px.b = t_chan'($urandom_range((1 << w) - 1));
            end
        endcase
        return px;
    endfunction

    function automatic t_pair rand_pair();
        t_pair px;
        int    s;
        int    rem;
        int    lo;
        int    hi;
        int unsigned ch;
        px.a = rand_rgb();
        px.b = rand_rgb();
        case ($urandom_range(9))
            0, 1, 2: begin
                // same channel sum, spread differently over A
                s      = int'(px.b.r) + int'(px.b.g) + int'(px.b.b);
                lo     = (s > 510) ? s - 510 : 0;
                hi     = (s < 255) ? s : 255;
                px.a.r = t_chan'($urandom_range(hi, lo));
                rem    = s - int'(px.a.r);
                lo     = (rem > 255) ? rem - 255 : 0;
                hi     = (rem < 255) ? rem : 255;
                px.a.g = t_chan'($urandom_range(hi, lo));
                px.a.b = t_chan'(rem - int'(px.a.g));
            end
            3, 4: begin
                // sums one apart
                px.a = px.b;
                ch   = $urandom_range(2);
                if (ch == 0) px.a.r = (px.a.r == 8'hFF) ? 8'hFE : px.a.r + 8'd1;
                else if (ch == 1) px.a.g = (px.a.g == 8'h00) ? 8'h01 : px.a.g - 8'd1;
                else px.a.b = (px.a.b == 8'hFF) ? 8'hFE : px.a.b + 8'd1;
            end
            default: ;
        endcase
        return px;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            fail_cnt++;
        end
    endtask

    // driver: next word goes out once the current one was taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (!i_start || word_taken) begin
            if (pixel_pairs_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
                next_pair = pixel_pairs_q.pop_front();
                i_a_red   <= next_pair.a.r;
                i_a_green <= next_pair.a.g;
                i_a_blue  <= next_pair.a.b;
                i_b_red   <= next_pair.b.r;
                i_b_green <= next_pair.b.g;
                i_b_blue  <= next_pair.b.b;
                i_start   <= 1'b1;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor: result check, prediction on accept, tint register mirror
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                if (tinted_q.size() == 0) begin
                    $display("%0t: unexpected result word %0d %0d %0d class %0d", $time,
                             o_out_red, o_out_green, o_out_blue, o_pixel_class);
                    fail_cnt++;
                end else begin
                    oldest = tinted_q.pop_front();
                    check_field("red", oldest.r, o_out_red);
                    check_field("green", oldest.g, o_out_green);
                    check_field("blue", oldest.b, o_out_blue);
                    check_field("class", 8'(oldest.cls), 8'(o_pixel_class));
                end
            end
            if (i_start && !o_busy) begin
                tinted_q.push_back(colorize({i_a_red, i_a_green, i_a_blue,
                                             i_b_red, i_b_green, i_b_blue}));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_COLOR_A_ONLY: tint_a_only = i_cfg_data;
                    CFG_COLOR_B_ONLY: tint_b_only = i_cfg_data;
                    CFG_COLOR_BOTH:   tint_both   = i_cfg_data;
                    default: ;
                endcase
            end
        end
        word_taken <= i_rst_n && i_start && !o_busy;
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WatchdogLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic wait_drained();
        @(negedge i_clk);
        while (pixel_pairs_q.size() != 0 || i_start || tinted_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic write_tint(t_cfg_idx idx, t_color value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_corners();
        @(posedge i_clk);
        foreach (CornerPairs[i]) pixel_pairs_q.push_back(t_pair'(CornerPairs[i]));
        wait_drained();
    endtask

    // one segment with a full drain halfway through
    task automatic run_segment(int unsigned gap, int unsigned count);
        @(posedge i_clk);
        gap_pct = gap;
        repeat (count / 2) pixel_pairs_q.push_back(rand_pair());
        wait_drained();
        @(posedge i_clk);
        repeat (count - count / 2) pixel_pairs_q.push_back(rand_pair());
        wait_drained();
    endtask

    initial begin
        int seg;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_corners();
        write_tint(CFG_COLOR_A_ONLY, 24'h000000);
        write_tint(CFG_COLOR_B_ONLY, 24'hFFFFFF);
        write_tint(CFG_COLOR_BOTH, 24'h00FF80);
        write_tint(CFG_UNUSED, t_color'($urandom));
        queue_corners();

        for (seg = 0; seg < 6; seg++) begin
            case (seg)
                3: begin
                    write_tint(CFG_COLOR_A_ONLY, 24'hFFFFFF);
                    write_tint(CFG_COLOR_B_ONLY, 24'h000000);
                    write_tint(CFG_COLOR_BOTH, 24'hFFFFFF);
                end
                5: begin
                    write_tint(CFG_COLOR_A_ONLY, 24'h000000);
                    write_tint(CFG_COLOR_B_ONLY, t_color'($urandom));
                    write_tint(CFG_COLOR_BOTH, 24'h000000);
                end
                default: begin
                    write_tint(CFG_COLOR_A_ONLY, t_color'($urandom));
                    write_tint(CFG_COLOR_B_ONLY, t_color'($urandom));
                    write_tint(CFG_COLOR_BOTH, t_color'($urandom));
                end
            endcase
            run_segment((seg < 2) ? 16 : ((seg < 4) ? 88 : 0), SegmentWords);
        end

        if (fail_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### pixel_diff_colorize.f
hw/rtl/pdc_pkg.sv
hw/rtl/pixel_diff_colorize.sv
dv/tb.sv
